>>> sv/cpd_pkg.sv
// Shared types, constants and the check digit function of the control packet deframer.
package cpd_pkg;

  localparam int unsigned PayloadLen = 7;
  localparam int unsigned FrameLen   = 8;
  localparam int unsigned CountMax   = 9;
  localparam int unsigned CountW     = 4;
  localparam int unsigned SumW       = 13;
  localparam int unsigned CheckMod   = 255;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BAD_LENGTH = 2'd1,
    ST_BAD_CHECK  = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_datagram;
  } item_t;

  typedef struct packed {
    status_e    status;
    logic [7:0] command_code;
    logic [7:0] axis_x_value;
    logic [7:0] axis_y_value;
    logic [7:0] axis_z_value;
    logic [7:0] axis_r_value;
    logic [7:0] camera_x_value;
    logic [7:0] camera_y_value;
  } result_t;

  // x mod 255 via 256 = 1 (mod 255): fold the bits above the low byte onto it, one correction.
  function automatic logic [7:0] mod255(input logic [SumW-1:0] x);
    logic [8:0] fold;
    fold = 9'(x[7:0]) + 9'(x[SumW-1:8]);
    if (fold >= 9'(CheckMod)) begin
      fold = fold - 9'(CheckMod);
    end
    return fold[7:0];
  endfunction

endpackage

>>> sv/cpd_in_stage.sv
// Input register stage of the control packet deframer.
module cpd_in_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  cpd_pkg::item_t item_i,
  input  logic           advance_i,
  output logic           valid_o,
  output cpd_pkg::item_t item_o
);
  import cpd_pkg::*;

  logic  valid_q;
  item_t item_q;

  assign in_stall_o = valid_q & ~advance_i;
  assign valid_o    = valid_q;
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q <= item_i;
    end
  end

endmodule

>>> sv/cpd_frame_check.sv
// Byte count, weighted sum, payload store and result logic of the deframer.
module cpd_frame_check (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               advance_i,
  input  cpd_pkg::item_t     item_i,
  output cpd_pkg::result_t   result_o,
  output logic [3:0]         count_o
);
  import cpd_pkg::*;

  logic [CountW-1:0] count_q, count_d;
  logic [SumW-1:0]   sum_q, sum_d;
  logic [7:0]        payload_q [PayloadLen];
  logic              in_payload;
  logic [2:0]        weight;
  logic [10:0]       product;

  assign in_payload = count_q < CountW'(PayloadLen);
  assign weight     = 3'(count_q[2:0] + 3'd1);
  assign product    = 11'(item_i.data_byte) * 11'(weight);
  assign count_o    = count_q;

  always_comb begin
    count_d = count_q;
    sum_d   = sum_q;
    if (in_payload) begin
      sum_d = SumW'(sum_q + SumW'(product));
    end
    if (item_i.end_of_datagram) begin
      count_d = '0;
      sum_d   = '0;
    end else if (count_q < CountW'(CountMax)) begin
      count_d = CountW'(count_q + CountW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
    end else if (advance_i) begin
      count_q <= count_d;
      sum_q   <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i && in_payload) begin
      payload_q[count_q[2:0]] <= item_i.data_byte;
    end
  end

  always_comb begin
    result_o = '0;
    if (count_q != CountW'(FrameLen - 1)) begin
      result_o.status = ST_BAD_LENGTH;
    end else if (item_i.data_byte != mod255(sum_q)) begin
      result_o.status = ST_BAD_CHECK;
    end else begin
      result_o.status         = ST_OK;
      result_o.command_code   = payload_q[0];
      result_o.axis_x_value   = payload_q[1];
      result_o.axis_y_value   = payload_q[2];
      result_o.axis_z_value   = payload_q[3];
      result_o.axis_r_value   = payload_q[4];
      result_o.camera_x_value = payload_q[5];
      result_o.camera_y_value = payload_q[6];
    end
  end

endmodule

>>> sv/cpd_out_reg.sv
// Result register of the control packet deframer.
module cpd_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  cpd_pkg::result_t result_i,
  output logic             ready_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output cpd_pkg::result_t result_o
);
  import cpd_pkg::*;

  logic    valid_q;
  result_t result_q;

  assign ready_o     = ~valid_q | ~out_stall_i;
  assign out_valid_o = valid_q;
  assign result_o    = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

endmodule

>>> sv/control_packet_deframer.sv
// Control packet deframer top level.
// Path: a marked last byte is held in the input register, then its result is loaded into the result register.
// Throughput: one byte per cycle; the input register stalls only while a finished
//   result waits in the output register and the next byte to process is a last byte.
// Reset: asynchronous, active low; clears count, sum and both valid flags.
//   The payload bytes are not reset.
module control_packet_deframer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_datagram_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] status_o,
  output logic [7:0] command_code_o,
  output logic [7:0] axis_x_value_o,
  output logic [7:0] axis_y_value_o,
  output logic [7:0] axis_z_value_o,
  output logic [7:0] axis_r_value_o,
  output logic [7:0] camera_x_value_o,
  output logic [7:0] camera_y_value_o
);
  import cpd_pkg::*;

  item_t      in_item, stage_item;
  logic       stage_valid, advance, out_ready, load;
  result_t    check_result, out_result;
  logic [3:0] count;

  assign in_item.data_byte       = data_byte_i;
  assign in_item.end_of_datagram = end_of_datagram_i;

  assign advance = stage_valid & (~stage_item.end_of_datagram | out_ready);
  assign load    = advance & stage_item.end_of_datagram;

  cpd_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .advance_i  (advance),
    .valid_o    (stage_valid),
    .item_o     (stage_item)
  );

  cpd_frame_check u_frame_check (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .item_i    (stage_item),
    .result_o  (check_result),
    .count_o   (count)
  );

  cpd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .result_i    (check_result),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (out_result)
  );

  assign status_o         = out_result.status;
  assign command_code_o   = out_result.command_code;
  assign axis_x_value_o   = out_result.axis_x_value;
  assign axis_y_value_o   = out_result.axis_y_value;
  assign axis_z_value_o   = out_result.axis_z_value;
  assign axis_r_value_o   = out_result.axis_r_value;
  assign camera_x_value_o = out_result.camera_x_value;
  assign camera_y_value_o = out_result.camera_y_value;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= 4'(CountMax))
    else $error("byte count beyond saturation");

  a_count_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> count == '0)
    else $error("byte count not cleared after last byte");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |->
      command_code_o == '0 && axis_x_value_o == '0 && camera_y_value_o == '0)
    else $error("error request carries payload");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i && stage_item.end_of_datagram)
    else $error("input stalled without a waiting request");

endmodule

>>> tb/tb.sv
// Self-checking testbench for the control packet deframer: directed and random datagrams.
`timescale 1ns / 100ps

module tb;
  import cpd_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  class frame_scoreboard;
    logic [3:0]  byte_pos;
    logic [12:0] pos_sum;
    logic [7:0]  payload[PayloadLen];
    result_t     expected_q[$];
    int          errors;
    int          status_seen[3];

    function new();
      byte_pos = '0;
      pos_sum  = '0;
      errors   = 0;
    endfunction

    // Predicts the effect of one accepted request.
    function void note_byte(logic [7:0] b, logic last);
      result_t    r;
      logic [3:0] pos;
      pos = byte_pos;
      if (pos < PayloadLen) begin
        payload[pos] = b;
        pos_sum = 13'(int'(pos_sum) + int'(b) * (int'(pos) + 1));
      end
      if (!last) begin
        if (byte_pos < CountMax) byte_pos = byte_pos + 4'd1;
        return;
      end
      r = '0;
      if (pos != FrameLen - 1) begin
        r.status = ST_BAD_LENGTH;
      end else if (int'(b) != int'(pos_sum) % CheckMod) begin
        r.status = ST_BAD_CHECK;
      end else begin
        r.status         = ST_OK;
        r.command_code   = payload[0];
        r.axis_x_value   = payload[1];
        r.axis_y_value   = payload[2];
        r.axis_z_value   = payload[3];
        r.axis_r_value   = payload[4];
        r.camera_x_value = payload[5];
        r.camera_y_value = payload[6];
      end
      expected_q.push_back(r);
      byte_pos = '0;
      pos_sum  = '0;
    endfunction

    function void compare_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
      if (got_v !== exp_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
      end
    endfunction

    function void check_result(result_t got);
      result_t exp_r;
      if (got.status < 3) status_seen[got.status]++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got status %0d", $time, got.status);
        return;
      end
      exp_r = expected_q.pop_front();
      compare_field("status", 8'(exp_r.status), 8'(got.status));
      compare_field("command_code", exp_r.command_code, got.command_code);
      compare_field("axis_x_value", exp_r.axis_x_value, got.axis_x_value);
      compare_field("axis_y_value", exp_r.axis_y_value, got.axis_y_value);
      compare_field("axis_z_value", exp_r.axis_z_value, got.axis_z_value);
      compare_field("axis_r_value", exp_r.axis_r_value, got.axis_r_value);
      compare_field("camera_x_value", exp_r.camera_x_value, got.camera_x_value);
      compare_field("camera_y_value", exp_r.camera_y_value, got.camera_y_value);
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni            = 1'b0;
  logic       in_valid_i        = 1'b0;
  logic       in_stall_o;
  logic [7:0] data_byte_i       = '0;
  logic       end_of_datagram_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i       = 1'b0;
  logic [1:0] status_o;
  logic [7:0] command_code_o;
  logic [7:0] axis_x_value_o;
  logic [7:0] axis_y_value_o;
  logic [7:0] axis_z_value_o;
  logic [7:0] axis_r_value_o;
  logic [7:0] camera_x_value_o;
  logic [7:0] camera_y_value_o;

  frame_scoreboard book;
  int tx_idle_pct  = 0;
  int rx_idle_pct  = 0;
  int hold_req     = 0;
  int bytes_sent   = 0;
  int stall_cycles = 0;

  control_packet_deframer u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .end_of_datagram_i(end_of_datagram_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .command_code_o   (command_code_o),
    .axis_x_value_o   (axis_x_value_o),
    .axis_y_value_o   (axis_y_value_o),
    .axis_z_value_o   (axis_z_value_o),
    .axis_r_value_o   (axis_r_value_o),
    .camera_x_value_o (camera_x_value_o),
    .camera_y_value_o (camera_y_value_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Receiver: random stall, or a long hold-off when one is requested.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < rx_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (in_valid_i && in_stall_o) stall_cycles++;
  end

  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.status         = status_e'(status_o);
      got.command_code   = command_code_o;
      got.axis_x_value   = axis_x_value_o;
      got.axis_y_value   = axis_y_value_o;
      got.axis_z_value   = axis_z_value_o;
      got.axis_r_value   = axis_r_value_o;
      got.camera_x_value = camera_x_value_o;
      got.camera_y_value = camera_y_value_o;
      book.check_result(got);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    data_byte_i       <= b;
    end_of_datagram_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    book.note_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_datagram(input byte_q_t bytes);
    int i;
    for (i = 0; i < bytes.size(); i++) begin
      send_byte(bytes[i], i == bytes.size() - 1);
    end
  endtask

  function automatic logic [7:0] rand_byte();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 8'h00;
    if (pick == 1) return 8'hff;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic byte_q_t make_frame(input bit corrupt);
    byte_q_t    f;
    int         i;
    int         acc;
    logic [7:0] chk;
    acc = 0;
    for (i = 0; i < PayloadLen; i++) begin
      f.push_back(rand_byte());
      acc += int'(f[i]) * (i + 1);
    end
    chk = 8'(acc % CheckMod);
    if (corrupt) chk = chk + 8'($urandom_range(1, 255));
    f.push_back(chk);
    return f;
  endfunction

  function automatic byte_q_t make_noise(input int len);
    byte_q_t f;
    int      i;
    for (i = 0; i < len; i++) f.push_back(rand_byte());
    return f;
  endfunction

  task automatic random_traffic(input int n_bytes);
    int      stop_at;
    int      pick;
    byte_q_t f;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 60)      f = make_frame(1'b0);
      else if (pick < 75) f = make_frame(1'b1);
      else if (pick < 88) f = make_noise($urandom_range(1, 12));
      else                f = make_noise($urandom_range(13, 40));
      send_datagram(f);
    end
  endtask

  initial begin
    int guard;
    book = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct = 36;
    rx_idle_pct = 52;
    // all ones: largest sum, check digit wraps to zero
    send_datagram('{8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'h00});
    // all zeros with a wrong check digit
    send_datagram('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hff});
    // lone marked byte, then one byte short
    send_datagram('{8'h5a});
    send_datagram('{8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07});
    random_traffic(350);

    tx_idle_pct = 52;
    rx_idle_pct = 36;
    random_traffic(370);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req    = 200;
    random_traffic(370);
    in_valid_i <= 1'b0;

    guard = 0;
    while (book.expected_q.size() != 0 && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (10) @(posedge clk_i);

    $display("Sent %0d bytes; results ok %0d, bad length %0d, bad check %0d.",
             bytes_sent, book.status_seen[0], book.status_seen[1], book.status_seen[2]);
    $display("Input stalled for %0d cycles; %0d results still outstanding.",
             stall_cycles, book.expected_q.size());
    if (book.errors == 0 && book.expected_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> files.f
sv/cpd_pkg.sv
sv/cpd_in_stage.sv
sv/cpd_frame_check.sv
sv/cpd_out_reg.sv
sv/control_packet_deframer.sv
tb/tb.sv
